/* sv/kpe_pkg.sv */
// Package for the keypad PIN and setpoint entry unit.
// Holds key codes, event codes, widths and the result word type.
// No dependencies; every other file in this block imports it.
package kpe_pkg;

  // Digit limits of the two entry modes.
  localparam int PIN_DIGITS          = 4;
  localparam int MAX_SETPOINT_DIGITS = 9;

  // Widths of the stored values and counters.
  localparam int PIN_W     = 14;
  localparam int PCNT_W    = $clog2(PIN_DIGITS + 1);
  localparam int SCNT_W    = $clog2(MAX_SETPOINT_DIGITS + 1);
  localparam int KEY_W     = 8;
  localparam int KIND_W    = 2;
  localparam int SP_BYTE_W = 8;

  // ASCII key codes.
  localparam logic [KEY_W-1:0] KEY_BACK  = 8'h23;
  localparam logic [KEY_W-1:0] KEY_ENTER = 8'h2A;
  localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
  localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;

  // Event codes reported on the result channel.
  localparam logic [KIND_W-1:0] EV_GRANTED  = 2'd0;
  localparam logic [KIND_W-1:0] EV_DENIED   = 2'd1;
  localparam logic [KIND_W-1:0] EV_SETPOINT = 2'd2;

  // Entry modes.
  localparam logic MODE_PIN      = 1'b0;
  localparam logic MODE_SETPOINT = 1'b1;

  // Result of one key word, handed from the core to the output register.
  typedef struct packed {
    logic                 valid;
    logic [KIND_W-1:0]    kind;
    logic [SP_BYTE_W-1:0] sp_byte;
  } kpe_result_t;

endpackage

/* sv/kpe_in_stage.sv */
// Input register of the keypad entry unit.
// Holds one key word until the core consumes it; depends on kpe_pkg.
module kpe_in_stage
  import kpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [KEY_W-1:0] in_tdata,
  input  logic             consume,
  output logic             key_valid,
  output logic [KEY_W-1:0] key_code
);

  logic             valid_r;
  logic             valid_nxt;
  logic [KEY_W-1:0] key_r;

  // The register takes a new word when empty or when its word leaves.
  assign in_tready = !valid_r || consume;
  assign valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (consume ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Key payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r <= in_tdata;
    end
  end

  assign key_valid = valid_r;
  assign key_code  = key_r;

endmodule

/* sv/kpe_core.sv */
// Entry state and per-key update of the keypad entry unit.
// Keeps PIN and setpoint prefix stacks; depends on kpe_pkg.
module kpe_core
  import kpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [KEY_W-1:0] key_code,
  input  logic             cfg_we,
  input  logic [PIN_W-1:0] cfg_wdata,
  output kpe_result_t      result
);

  // Configured access code.
  logic [PIN_W-1:0] pin_code_r;

  // Control state.
  logic              mode_r, mode_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [SCNT_W-1:0] scnt_r, scnt_nxt;
  logic              seen_r, seen_nxt;

  // Prefix stacks: entry 0 holds the value of all digits held, entry 1 the
  // value without the last digit, and so on. The setpoint stack keeps only
  // the low byte, which is all that is ever reported.
  logic [PIN_W-1:0]     pin_stk_r [PIN_DIGITS];
  logic [PIN_W-1:0]     pin_stk_nxt [PIN_DIGITS];
  logic [SP_BYTE_W-1:0] sp_stk_r [MAX_SETPOINT_DIGITS];
  logic [SP_BYTE_W-1:0] sp_stk_nxt [MAX_SETPOINT_DIGITS];

  // Key decode.
  logic                 is_digit;
  logic                 is_back;
  logic                 is_enter;
  logic [3:0]           digit;
  logic [PIN_W-1:0]     pin_top;
  logic [PIN_W+3:0]     pin_times10;
  logic [PIN_W-1:0]     pin_push;
  logic [SP_BYTE_W-1:0] sp_top;
  logic [SP_BYTE_W-1:0] sp_push;
  logic                 pin_match;

  assign is_digit = (key_code >= KEY_ZERO) && (key_code <= KEY_NINE);
  assign is_back  = (key_code == KEY_BACK);
  assign is_enter = (key_code == KEY_ENTER);
  assign digit    = key_code[3:0];

  // New prefix values: an empty stack counts as zero.
  assign pin_top     = (pcnt_r == '0) ? '0 : pin_stk_r[0];
  assign pin_times10 = {1'b0, pin_top, 3'b000} + {3'b000, pin_top, 1'b0};
  assign pin_push    = pin_times10[PIN_W-1:0] + {{(PIN_W-4){1'b0}}, digit};
  assign sp_top      = (scnt_r == '0) ? '0 : sp_stk_r[0];
  assign sp_push     = {sp_top[SP_BYTE_W-4:0], 3'b000} + {sp_top[SP_BYTE_W-2:0], 1'b0}
                       + {{(SP_BYTE_W-4){1'b0}}, digit};
  assign pin_match   = (pin_stk_r[0] == pin_code_r);

  // Next-state and result logic for one key.
  always_comb begin
    mode_nxt    = mode_r;
    pcnt_nxt    = pcnt_r;
    scnt_nxt    = scnt_r;
    seen_nxt    = seen_r;
    pin_stk_nxt = pin_stk_r;
    sp_stk_nxt  = sp_stk_r;
    result      = '0;

    if (mode_r == MODE_PIN) begin
      if (is_back) begin
        if (pcnt_r != '0) begin
          pcnt_nxt = pcnt_r - PCNT_W'(1);
          for (int i = 0; i < PIN_DIGITS - 1; i++) begin
            pin_stk_nxt[i] = pin_stk_r[i+1];
          end
        end
      end else if (is_digit) begin
        if (pcnt_r < PCNT_W'(PIN_DIGITS)) begin
          pcnt_nxt       = pcnt_r + PCNT_W'(1);
          pin_stk_nxt[0] = pin_push;
          for (int i = 1; i < PIN_DIGITS; i++) begin
            pin_stk_nxt[i] = pin_stk_r[i-1];
          end
        end
      end else if (is_enter) begin
        if (pcnt_r == PCNT_W'(PIN_DIGITS)) begin
          pcnt_nxt     = '0;
          result.valid = 1'b1;
          result.kind  = pin_match ? EV_GRANTED : EV_DENIED;
          if (pin_match) begin
            mode_nxt = MODE_SETPOINT;
            scnt_nxt = '0;
            seen_nxt = 1'b0;
          end
        end
      end
    end else begin
      if (is_back) begin
        if (scnt_r != '0) begin
          scnt_nxt = scnt_r - SCNT_W'(1);
          for (int i = 0; i < MAX_SETPOINT_DIGITS - 1; i++) begin
            sp_stk_nxt[i] = sp_stk_r[i+1];
          end
        end
      end else if (is_digit) begin
        if (scnt_r < SCNT_W'(MAX_SETPOINT_DIGITS)) begin
          scnt_nxt      = scnt_r + SCNT_W'(1);
          seen_nxt      = 1'b1;
          sp_stk_nxt[0] = sp_push;
          for (int i = 1; i < MAX_SETPOINT_DIGITS; i++) begin
            sp_stk_nxt[i] = sp_stk_r[i-1];
          end
        end
      end else if (is_enter) begin
        // A session in which every digit was deleted still reports zero.
        result.valid   = seen_r;
        result.kind    = EV_SETPOINT;
        result.sp_byte = sp_top;
        scnt_nxt       = '0;
        seen_nxt       = 1'b0;
        pcnt_nxt       = '0;
        mode_nxt       = MODE_PIN;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_PIN;
      pcnt_r     <= '0;
      scnt_r     <= '0;
      seen_r     <= 1'b0;
      pin_code_r <= PIN_W'(2222);
    end else begin
      if (step) begin
        mode_r <= mode_nxt;
        pcnt_r <= pcnt_nxt;
        scnt_r <= scnt_nxt;
        seen_r <= seen_nxt;
      end
      if (cfg_we) begin
        pin_code_r <= cfg_wdata;
      end
    end
  end

  // Stack payload; entries beyond the count are never read.
  always_ff @(posedge clk) begin
    if (step) begin
      pin_stk_r <= pin_stk_nxt;
      sp_stk_r  <= sp_stk_nxt;
    end
  end

  // Counters never pass their limits.
  a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCNT_W'(PIN_DIGITS))
    else $error("PIN digit count above limit");

  a_scnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    scnt_r <= SCNT_W'(MAX_SETPOINT_DIGITS))
    else $error("setpoint digit count above limit");

  // Setpoint state is empty in PIN mode, PIN state is empty in setpoint mode.
  a_mode_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_PIN) |-> (scnt_r == '0 && !seen_r))
    else $error("setpoint state left over in PIN mode");

  a_setpoint_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_SETPOINT) |-> (pcnt_r == '0))
    else $error("PIN digits held in setpoint mode");

  // A grant always opens a setpoint session.
  a_grant_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (step && result.valid && result.kind == EV_GRANTED) |=> (mode_r == MODE_SETPOINT))
    else $error("grant did not enter setpoint mode");

endmodule

/* sv/kpe_out_stage.sv */
// Output register of the keypad entry unit.
// Holds one result word until the sink takes it; depends on kpe_pkg.
module kpe_out_stage
  import kpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  kpe_result_t result,
  output logic        slot_free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);

  logic                 valid_r, valid_nxt;
  logic [KIND_W-1:0]    kind_r;
  logic [SP_BYTE_W-1:0] sp_byte_r;
  logic                 load;

  // The slot is free when empty or when its word leaves this cycle.
  assign slot_free = !valid_r || out_tready;
  assign load      = step && result.valid;
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r    <= result.kind;
      sp_byte_r <= result.sp_byte;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'b000000, sp_byte_r, kind_r};

endmodule

/* sv/keypad_pin_and_setpoint_entry_unit.sv */
// Keypad PIN check and setpoint entry: top level.
// A key word waits in the input register until the output register is free;
// the core's update then loads its result word, offered on out_tvalid.
// Throughput: one key word per cycle while out_tready does not hold the output.
// Reset (rst_n low, synchronous) empties both registers, enters PIN mode with
// no digits held, and sets the access code to 2222.
module keypad_pin_and_setpoint_entry_unit
  import kpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] key_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [1:0] event_kind, [9:2] setpoint_byte, [15:10] zero
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata    // pin_code
);

  logic             key_valid;
  logic [KEY_W-1:0] key_code;
  logic             slot_free;
  logic             step;
  kpe_result_t      result;

  // A key word is processed once the output register can take its result.
  assign step = key_valid && slot_free;

  kpe_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .consume   (step),
    .key_valid (key_valid),
    .key_code  (key_code)
  );

  kpe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .key_code  (key_code),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  kpe_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .result     (result),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
